// ===== sv/aes128_cbc_padded_engine_top_macros.svh =====
// assertion helpers shared by the engine rtl
`ifndef AES128_CBC_PADDED_ENGINE_TOP_MACROS_SVH
`define AES128_CBC_PADDED_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define AES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/aescbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescbc_pkg
// types, tables and gf helpers for the aes-128 cbc engine
// ----------------------------------------------------------------------------
package aescbc_pkg;

	localparam int NumRounds = 10;
	localparam int RndW      = 4;

	typedef logic [0:255][7:0] tbl_t;

	typedef enum logic [2:0] {
		REG_KEY_HIGH = 3'd0,
		REG_KEY_LOW  = 3'd1,
		REG_IV_HIGH  = 3'd2,
		REG_IV_LOW   = 3'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_DONE
	} eng_state_t;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam tbl_t SBOX = {
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// inverse table derived at elaboration
	function automatic tbl_t build_inv();
		tbl_t t;
		t = '0;
		for (int i = 0; i < 256; i++) begin
			t[SBOX[i]] = 8'(i);
		end
		return t;
	endfunction

	localparam tbl_t INV_SBOX = build_inv();

	function automatic logic [7:0] sub_byte(input logic [7:0] a);
		return SBOX[a];
	endfunction

	function automatic logic [7:0] inv_sub_byte(input logic [7:0] a);
		return INV_SBOX[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] mul9(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ a;
	endfunction

	function automatic logic [7:0] mul11(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
	endfunction

	function automatic logic [7:0] mul13(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
	endfunction

	function automatic logic [7:0] mul14(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
	endfunction

endpackage

// ===== sv/aescbc_keyexp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescbc_keyexp
// sequential key schedule: one round key per cycle into a register file
// ----------------------------------------------------------------------------
module aescbc_keyexp import aescbc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] key,
	input  logic [3:0]   rd_idx,
	output logic [127:0] rd_key,
	output logic         busy
);

	logic [127:0] rk_q [NumRounds+1];
	logic [127:0] work_q;
	logic [7:0]   rcon_q;
	logic [3:0]   cnt_q;
	logic         busy_q;
	logic [127:0] next_key;
	logic [31:0]  tw;

	always_comb begin
		tw = {sub_byte(work_q[23:16]) ^ rcon_q, sub_byte(work_q[15:8]),
			sub_byte(work_q[7:0]), sub_byte(work_q[31:24])};
		next_key[127:96] = work_q[127:96] ^ tw;
		next_key[95:64]  = work_q[95:64] ^ next_key[127:96];
		next_key[63:32]  = work_q[63:32] ^ next_key[95:64];
		next_key[31:0]   = work_q[31:0] ^ next_key[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd1;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(NumRounds)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q   <= key;
			rcon_q   <= 8'h01;
			rk_q[0]  <= key;
		end else if (busy_q) begin
			work_q      <= next_key;
			rcon_q      <= xtime(rcon_q);
			rk_q[cnt_q] <= next_key;
		end
	end

	assign rd_key = rk_q[rd_idx];
	assign busy   = busy_q;

endmodule

// ===== sv/aescbc_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescbc_round
// shared aes round: forward or inverse, final round skips the column mix
// ----------------------------------------------------------------------------
module aescbc_round import aescbc_pkg::*; (
	input  logic [127:0] state_in,
	input  logic [127:0] rkey,
	input  logic         dec,
	input  logic         last,
	output logic [127:0] state_out
);

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state_in[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (dec) begin
					t[((c + r) % 4) * 4 + r] = inv_sub_byte(s[c*4+r]) ^
						rkey[127-8*(((c + r) % 4) * 4 + r) -: 8];
				end else begin
					t[c*4+r] = sub_byte(s[((c + r) % 4) * 4 + r]);
				end
			end
		end
		for (int c = 0; c < 4; c++) begin
			if (dec) begin
				m[c*4]   = mul14(t[c*4]) ^ mul11(t[c*4+1]) ^ mul13(t[c*4+2]) ^ mul9(t[c*4+3]);
				m[c*4+1] = mul9(t[c*4]) ^ mul14(t[c*4+1]) ^ mul11(t[c*4+2]) ^ mul13(t[c*4+3]);
				m[c*4+2] = mul13(t[c*4]) ^ mul9(t[c*4+1]) ^ mul14(t[c*4+2]) ^ mul11(t[c*4+3]);
				m[c*4+3] = mul11(t[c*4]) ^ mul13(t[c*4+1]) ^ mul9(t[c*4+2]) ^ mul14(t[c*4+3]);
			end else begin
				m[c*4]   = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3] ^ t[c*4] ^
					xtime(t[c*4] ^ t[c*4+1]);
				m[c*4+1] = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3] ^ t[c*4+1] ^
					xtime(t[c*4+1] ^ t[c*4+2]);
				m[c*4+2] = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3] ^ t[c*4+2] ^
					xtime(t[c*4+2] ^ t[c*4+3]);
				m[c*4+3] = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3] ^ t[c*4+3] ^
					xtime(t[c*4+3] ^ t[c*4]);
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (dec) begin
				state_out[127-8*i -: 8] = last ? t[i] : m[i];
			end else begin
				state_out[127-8*i -: 8] = (last ? t[i] : m[i]) ^ rkey[127-8*i -: 8];
			end
		end
	end

endmodule

// ===== sv/aes128_cbc_padded_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cbc_padded_engine_top
// aes-128 cbc block engine with pkcs7 padding on encrypt, unpad count on decrypt
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// in      | in_valid / in_ready  | cmd, text_hi, text_lo, byte_count, last_block,
//         |                      | chain_start
// out     | out_valid / out_ready| out_hi, out_lo, out_bytes
// cfg     | cfg_we               | cfg_idx, cfg_wdata
//
// a block is loaded with the initial key add, makes ten passes through the
// single shared round unit, then is written to the output register.
// a new request is taken only once the previous block reaches the output register.
// after reset and after every key write the schedule is rebuilt, and while it is
// rebuilt no request is taken.
// a full output register holds the finished block until it is taken.
// ----------------------------------------------------------------------------
`include "aes128_cbc_padded_engine_top_macros.svh"

module aes128_cbc_padded_engine_top import aescbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [63:0] text_hi,
	input  logic [63:0] text_lo,
	input  logic [4:0]  byte_count,
	input  logic        last_block,
	input  logic        chain_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_hi,
	output logic [63:0] out_lo,
	output logic [4:0]  out_bytes,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_wdata
);

	eng_state_t   fsm_q, fsm_d;
	logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic         kpend_q;
	logic         kexp_busy;
	logic [127:0] rkey;
	logic [3:0]   rk_idx;
	logic [127:0] state_q, prev_q, chain_q, round_out, prev_d, padded;
	logic [3:0]   rnd_q;
	logic         dec_q, last_q;
	logic         out_valid_q;
	logic [127:0] out_q;
	logic [4:0]   out_bytes_q;
	logic         accept, finish;
	logic [127:0] result;
	logic [7:0]   tail;
	logic [4:0]   cnt_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			iv_hi_q  <= '0;
			iv_lo_q  <= '0;
			kpend_q  <= 1'b1;
		end else begin
			kpend_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					REG_KEY_HIGH: begin
						key_hi_q <= cfg_wdata;
						kpend_q  <= 1'b1;
					end
					REG_KEY_LOW: begin
						key_lo_q <= cfg_wdata;
						kpend_q  <= 1'b1;
					end
					REG_IV_HIGH: iv_hi_q <= cfg_wdata;
					REG_IV_LOW:  iv_lo_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	aescbc_keyexp u_keyexp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (kpend_q),
		.key    ({key_hi_q, key_lo_q}),
		.rd_idx (rk_idx),
		.rd_key (rkey),
		.busy   (kexp_busy)
	);

	aescbc_round u_round (
		.state_in  (state_q),
		.rkey      (rkey),
		.dec       (dec_q),
		.last      (rnd_q == 4'(NumRounds)),
		.state_out (round_out)
	);

	// next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			ST_IDLE:  if (accept) fsm_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 4'(NumRounds)) fsm_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || out_ready) fsm_d = ST_IDLE;
			default:  fsm_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		finish   = 1'b0;
		case (fsm_q)
			ST_IDLE: in_ready = !kpend_q && !kexp_busy;
			ST_DONE: finish = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_comb begin
		if (fsm_q == ST_IDLE) begin
			rk_idx = (cmd == CMD_DECRYPT) ? 4'(NumRounds) : 4'd0;
		end else begin
			rk_idx = dec_q ? 4'(NumRounds) - rnd_q : rnd_q;
		end
	end

	always_comb begin
		prev_d = chain_start ? {iv_hi_q, iv_lo_q} : chain_q;
		padded = {text_hi, text_lo};
		if (byte_count < 5'd16) begin
			for (int i = 0; i < 16; i++) begin
				if (5'(i) >= byte_count) begin
					padded[127-8*i -: 8] = 8'(5'd16 - byte_count);
				end
			end
		end
	end

	// finish: unchain on decrypt and count the pad of a last decrypted block
	always_comb begin
		result = dec_q ? (state_q ^ prev_q) : state_q;
		tail   = result[7:0];
		if (dec_q && last_q) begin
			cnt_d = (tail < 8'd16) ? 5'(9'd16 - {1'b0, tail}) : 5'd0;
		end else begin
			cnt_d = 5'd16;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= ST_IDLE;
			rnd_q       <= '0;
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (accept) begin
				rnd_q <= 4'd1;
				if (cmd == CMD_DECRYPT) begin
					chain_q <= {text_hi, text_lo};
				end
			end else if (fsm_q == ST_ROUND) begin
				rnd_q <= rnd_q + 4'd1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				if (!dec_q) begin
					chain_q <= state_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_q <= prev_d;
			dec_q  <= cmd;
			last_q <= last_block;
			if (cmd == CMD_DECRYPT) begin
				state_q <= {text_hi, text_lo} ^ rkey;
			end else begin
				state_q <= padded ^ prev_d ^ rkey;
			end
		end else if (fsm_q == ST_ROUND) begin
			state_q <= round_out;
		end
		if (finish) begin
			out_q       <= result;
			out_bytes_q <= cnt_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hi    = out_q[127:64];
	assign out_lo    = out_q[63:0];
	assign out_bytes = out_bytes_q;

	`AES_ASSERT_NEXT(a_accept_starts_rounds, accept, fsm_q == ST_ROUND, "request did not start rounds")
	`AES_ASSERT_NOW(a_round_range, fsm_q == ST_ROUND, rnd_q >= 4'd1 && rnd_q <= 4'(NumRounds), "round count out of range")
	`AES_ASSERT_NOW(a_no_accept_in_expand, kexp_busy || kpend_q, !in_ready, "request taken during key expansion")
	`AES_ASSERT_NEXT(a_finish_fills_out, finish, out_valid_q && fsm_q == ST_IDLE, "finished block not registered")

endmodule

// ===== test/aes128_cbc_padded_engine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cbc_padded_engine_checker
// watches the request and result channels and the register port, predicts
// every result with a behavioral aes-128 cbc model and compares field by field
// ----------------------------------------------------------------------------
module aes128_cbc_padded_engine_checker import aescbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        cmd,
	input  logic [63:0] text_hi,
	input  logic [63:0] text_lo,
	input  logic [4:0]  byte_count,
	input  logic        last_block,
	input  logic        chain_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] out_hi,
	input  logic [63:0] out_lo,
	input  logic [4:0]  out_bytes,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	typedef logic [7:0] blk_t [16];

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [4:0]  nbytes;
	} cbc_result_t;

	cbc_result_t result_q[$];
	logic [63:0] key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
	logic [63:0] chain_hi, chain_lo;
	logic [7:0]  sched [176];
	logic [7:0]  sb [256];
	logic [7:0]  isb [256];

	assign pending = result_q.size();

	function automatic logic [7:0] gmul2(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int n = 0; n < 8; n++) begin
			if (b[n]) p ^= a;
			a = gmul2(a);
		end
		return p;
	endfunction

	// s-box built from the field inverse and the affine map
	function automatic void build_sbox();
		logic [7:0] inv, r, base, b;
		for (int x = 0; x < 256; x++) begin
			inv = '0;
			if (x != 0) begin
				r = 8'd1;
				base = x[7:0];
				for (int e = 0; e < 8; e++) begin
					if ((254 >> e) & 1) r = gmul(r, base);
					base = gmul(base, base);
				end
				inv = r;
			end
			b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sb[x] = b;
			isb[b] = x[7:0];
		end
	endfunction

	function automatic blk_t to_bytes(logic [63:0] hi, logic [63:0] lo);
		blk_t b;
		for (int i = 0; i < 8; i++) begin
			b[i] = hi[63-8*i -: 8];
			b[8+i] = lo[63-8*i -: 8];
		end
		return b;
	endfunction

	function automatic void expand_schedule();
		blk_t k;
		logic [7:0] t [4];
		logic [7:0] rc, f;
		k = to_bytes(key_hi_r, key_lo_r);
		for (int i = 0; i < 16; i++) sched[i] = k[i];
		rc = 8'd1;
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++) t[j] = sched[4*i-4+j];
			if ((i & 3) == 0) begin
				f = t[0];
				t[0] = sb[t[1]] ^ rc;
				t[1] = sb[t[2]];
				t[2] = sb[t[3]];
				t[3] = sb[f];
				rc = gmul2(rc);
			end
			for (int j = 0; j < 4; j++) sched[4*i+j] = sched[4*i-16+j] ^ t[j];
		end
	endfunction

	function automatic blk_t cipher_fwd(blk_t s);
		blk_t t;
		logic [7:0] a0, a1, a2, a3, all;
		for (int i = 0; i < 16; i++) s[i] ^= sched[i];
		for (int r = 1; r <= NumRounds; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) t[c*4+i] = sb[s[((c+i)&3)*4+i]];
			if (r != NumRounds) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					t[c*4]   = a0 ^ all ^ gmul2(a0 ^ a1);
					t[c*4+1] = a1 ^ all ^ gmul2(a1 ^ a2);
					t[c*4+2] = a2 ^ all ^ gmul2(a2 ^ a3);
					t[c*4+3] = a3 ^ all ^ gmul2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ sched[r*16+i];
		end
		return s;
	endfunction

	function automatic blk_t cipher_inv(blk_t s);
		blk_t t;
		logic [7:0] a0, a1, a2, a3;
		for (int i = 0; i < 16; i++) s[i] ^= sched[160+i];
		for (int r = NumRounds - 1; r >= 0; r--) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) t[((c+i)&3)*4+i] = isb[s[c*4+i]];
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ sched[r*16+i];
			if (r != 0) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
					s[c*4]   = gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9);
					s[c*4+1] = gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13);
					s[c*4+2] = gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11);
					s[c*4+3] = gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14);
				end
			end
		end
		return s;
	endfunction

	function automatic cbc_result_t predict_block();
		blk_t b, p;
		cbc_result_t res;
		b = to_bytes(text_hi, text_lo);
		p = chain_start ? to_bytes(iv_hi_r, iv_lo_r) : to_bytes(chain_hi, chain_lo);
		res.nbytes = 5'd16;
		if (cmd == CMD_ENCRYPT) begin
			if (byte_count < 16)
				for (int i = byte_count; i < 16; i++) b[i] = 8'(16 - byte_count);
			for (int i = 0; i < 16; i++) b[i] ^= p[i];
			b = cipher_fwd(b);
		end else begin
			b = cipher_inv(b);
			for (int i = 0; i < 16; i++) b[i] ^= p[i];
			if (last_block) res.nbytes = (b[15] < 16) ? 5'(16 - b[15]) : 5'd0;
		end
		for (int i = 0; i < 8; i++) begin
			res.hi[63-8*i -: 8] = b[i];
			res.lo[63-8*i -: 8] = b[8+i];
		end
		if (cmd == CMD_ENCRYPT) begin
			chain_hi = res.hi;
			chain_lo = res.lo;
		end else begin
			chain_hi = text_hi;
			chain_lo = text_lo;
		end
		return res;
	endfunction

	initial begin
		build_sbox();
		fail_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		cbc_result_t exp_r;
		if (!arst_n) begin
			key_hi_r = '0; key_lo_r = '0; iv_hi_r = '0; iv_lo_r = '0;
			chain_hi = '0; chain_lo = '0;
			result_q.delete();
			expand_schedule();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_KEY_HIGH: begin key_hi_r = cfg_wdata; expand_schedule(); end
					REG_KEY_LOW:  begin key_lo_r = cfg_wdata; expand_schedule(); end
					REG_IV_HIGH:  iv_hi_r = cfg_wdata;
					REG_IV_LOW:   iv_lo_r = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) result_q.push_back(predict_block());
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result with no request pending");
					fail_count++;
				end else begin
					exp_r = result_q.pop_front();
					if (out_hi !== exp_r.hi) begin
						$error("out_hi expected %h actual %h", exp_r.hi, out_hi);
						fail_count++;
					end
					if (out_lo !== exp_r.lo) begin
						$error("out_lo expected %h actual %h", exp_r.lo, out_lo);
						fail_count++;
					end
					if (out_bytes !== exp_r.nbytes) begin
						$error("out_bytes expected %0d actual %0d", exp_r.nbytes, out_bytes);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== test/tb_aes128_cbc_padded_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_cbc_padded_engine_top
// drives directed and random cbc encrypt/decrypt requests through several
// key and iv settings with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module tb_aes128_cbc_padded_engine_top import aescbc_pkg::*;;

	logic        clk, arst_n;
	logic        in_valid, in_ready, cmd, last_block, chain_start;
	logic [63:0] text_hi, text_lo, out_hi, out_lo, cfg_wdata;
	logic [4:0]  byte_count, out_bytes;
	logic        out_valid, out_ready, cfg_we;
	logic [2:0]  cfg_idx;
	int          fail_count, pending;
	int          cycle_cnt;
	bit          hold_long;

	aes128_cbc_padded_engine_top DUT (.*);
	aes128_cbc_padded_engine_checker u_checker (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 2000000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stall pattern, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		int stall_left;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else if (hold_long) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0) stall_left = int'($urandom_range(1, 20));
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_block(logic c, logic [63:0] hi, logic [63:0] lo, logic [4:0] cnt,
		logic lb, logic cs);
		in_valid <= 1'b1;
		cmd <= c; text_hi <= hi; text_lo <= lo;
		byte_count <= cnt; last_block <= lb; chain_start <= cs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic idle_gap();
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random message: chain start, full blocks, then a closing block, with an occasional fully random block
	task automatic send_message();
		logic enc;
		int nblk;
		enc = 1'($urandom_range(0, 1));
		nblk = int'($urandom_range(1, 5));
		for (int i = 0; i < nblk; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				send_block(1'($urandom), rand64(), rand64(), 5'($urandom), 1'($urandom),
					1'($urandom));
			end else if (enc == CMD_ENCRYPT) begin
				send_block(CMD_ENCRYPT, rand64(), rand64(),
					(i == nblk - 1) ? 5'($urandom_range(0, 16)) : 5'(16 + $urandom_range(0, 15)),
					1'($urandom), i == 0);
			end else begin
				send_block(CMD_DECRYPT, rand64(), rand64(), 5'($urandom), i == nblk - 1, i == 0);
			end
			if ($urandom_range(0, 2) == 0) idle_gap();
		end
	endtask

	initial begin
		int sent;
		arst_n = 1'b0;
		in_valid = 1'b0; cmd = 1'b0; text_hi = '0; text_lo = '0; byte_count = '0;
		last_block = 1'b0; chain_start = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
		hold_long = 1'b0; cycle_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all-zero key, then extremes of every field
		send_block(CMD_ENCRYPT, '0, '0, 5'd16, 1'b0, 1'b1);
		send_block(CMD_ENCRYPT, '1, '1, 5'd31, 1'b1, 1'b0);
		send_block(CMD_ENCRYPT, '0, '0, 5'd0, 1'b0, 1'b0);
		send_block(CMD_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b0, 1'b1);
		send_block(CMD_ENCRYPT, '1, '0, 5'd1, 1'b0, 1'b0);
		drain();
		write_reg(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
		write_reg(REG_KEY_LOW, 64'habf7158809cf4f3c);
		write_reg(REG_IV_HIGH, 64'h0001020304050607);
		write_reg(REG_IV_LOW, 64'h08090a0b0c0d0e0f);
		write_reg(cfg_reg_t'(3'd7), '1);
		repeat (20) @(posedge clk);
		send_block(CMD_ENCRYPT, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b0, 1'b1);
		send_block(CMD_DECRYPT, 64'h7649abac8119b246, 64'hcee98e9b12e9197d, 5'd0, 1'b0, 1'b1);
		send_block(CMD_DECRYPT, '0, '0, 5'd31, 1'b1, 1'b0);
		send_block(CMD_DECRYPT, '1, '1, 5'd16, 1'b1, 1'b1);
		send_block(CMD_ENCRYPT, 64'h1111, 64'h2222, 5'd8, 1'b1, 1'b1);
		send_block(CMD_DECRYPT, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 5'd3, 1'b1, 1'b0);
		drain();

		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_KEY_HIGH, '1); write_reg(REG_KEY_LOW, '1);
					write_reg(REG_IV_HIGH, '1); write_reg(REG_IV_LOW, '1);
				end
				1: begin
					write_reg(REG_KEY_HIGH, '0); write_reg(REG_KEY_LOW, '0);
					write_reg(REG_IV_HIGH, '0); write_reg(REG_IV_LOW, '0);
				end
				default: begin
					write_reg(REG_KEY_HIGH, rand64()); write_reg(REG_KEY_LOW, rand64());
					write_reg(REG_IV_HIGH, rand64()); write_reg(REG_IV_LOW, rand64());
				end
			endcase
			repeat (20) @(posedge clk);
			if (ph == 2) begin
				// long receiver hold-off while requests keep coming
				fork
					begin
						hold_long <= 1'b1;
						repeat (300) @(posedge clk);
						hold_long <= 1'b0;
					end
				join_none
			end
			while (sent < (ph + 1) * 200) begin
				send_message();
				sent += 3;
				idle_gap();
			end
			drain();
		end

		if (fail_count == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
